>>> design/pvc_pkg.sv
// Shared types and constants for the pricing vertex cover block.
// No dependencies; every other design file but pvc_table imports this package.
`default_nettype none

package pvc_pkg;

  // Widths of the fixed payload fields.
  localparam int unsigned ID_W    = 10;
  localparam int unsigned FIELD_W = 16;

  // Item kinds on the input channel.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EDGE = 1'b1
  } action_e;

  // Decision for one edge, passed from the charge logic to the control.
  typedef struct packed {
    logic emit;        // both endpoints still carry weight, so the edge is charged
    logic first_wins;  // the first endpoint has the strictly smaller weight
    logic self_loop;   // both endpoints name the same vertex
  } charge_t;

endpackage

`default_nettype wire

>>> design/pvc_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on pvc_pkg for the field widths.
`default_nettype none

interface pvc_item_if;
  import pvc_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    first_vertex;
  logic [ID_W-1:0]    second_vertex;
  logic [FIELD_W-1:0] weight;

  modport source (output valid, output action, output first_vertex,
                  output second_vertex, output weight, input ready);
  modport sink   (input valid, input action, input first_vertex,
                  input second_vertex, input weight, output ready);
endinterface

interface pvc_result_if;
  import pvc_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    cover_vertex;
  logic [FIELD_W-1:0] price;

  modport source (output valid, output cover_vertex, output price, input ready);
  modport sink   (input valid, input cover_vertex, input price, output ready);
endinterface

`default_nettype wire

>>> design/pvc_table.sv
// Dual-port remaining-weight memory with registered read data.
// Depends on nothing; instantiated by the core.
`default_nettype none

module pvc_table #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             en0_i,
  input  wire logic             we0_i,
  input  wire logic [AddrW-1:0] addr0_i,
  input  wire logic [DataW-1:0] wdata0_i,
  output logic      [DataW-1:0] rdata0_o,
  input  wire logic             en1_i,
  input  wire logic             we1_i,
  input  wire logic [AddrW-1:0] addr1_i,
  input  wire logic [DataW-1:0] wdata1_i,
  output logic      [DataW-1:0] rdata1_o
);

  logic [DataW-1:0] mem [Depth];

  // Both ports read or write one entry per cycle; reads hold when disabled.
  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      if (we0_i) begin
        mem[addr0_i] <= wdata0_i;
      end else begin
        rdata0_o <= mem[addr0_i];
      end
    end
    if (en1_i) begin
      if (we1_i) begin
        mem[addr1_i] <= wdata1_i;
      end else begin
        rdata1_o <= mem[addr1_i];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/pvc_charge.sv
// Edge charge logic: picks the winner, the price and the loser's remainder.
// Depends on pvc_pkg for the decision struct.
`default_nettype none

module pvc_charge
  import pvc_pkg::*;
#(
  parameter int unsigned WeightW = 16
) (
  input  wire logic [WeightW-1:0] first_w_i,
  input  wire logic [WeightW-1:0] second_w_i,
  input  wire logic               same_id_i,
  output charge_t                 charge_o,
  output logic      [WeightW-1:0] price_o,
  output logic      [WeightW-1:0] rest_o
);

  // The smaller weight wins; on a tie the second endpoint wins.
  always_comb begin
    charge_o.emit       = (first_w_i != '0) && (second_w_i != '0);
    charge_o.first_wins = first_w_i < second_w_i;
    charge_o.self_loop  = same_id_i;
    if (charge_o.first_wins) begin
      price_o = first_w_i;
      rest_o  = second_w_i - first_w_i;
    end else begin
      price_o = second_w_i;
      rest_o  = first_w_i - second_w_i;
    end
  end

endmodule

`default_nettype wire

>>> design/pricing_vertex_cover_approx_core.sv
// Top level of the pricing-method weighted vertex cover block.
// Depends on pvc_pkg, pvc_if, pvc_table and pvc_charge.
//
//   channel   dir  beat contents
//   item_i    in   action, first_vertex, second_vertex, weight
//   result_o  out  cover_vertex, price
//
// A load beat writes the table at the edge it is accepted. An edge beat reads
// both endpoints on the two memory ports; if it is charged, the charge stage then
// writes the entries back on the same ports.
// Reset clears only control state; the weight table has no clearing pass.
// A charged edge waits in the charge stage while the result register is full
// and not being taken; no new beat is accepted during that time.
`default_nettype none

module pricing_vertex_cover_approx_core
  import pvc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pvc_item_if.sink    item_i,
  pvc_result_if.source result_o
);

  localparam int unsigned AddrW = $clog2(MAX_VERTICES);

  // Accept and address decode.
  logic                   accept;
  logic                   is_edge;
  logic [31:0]            first_ext, second_ext, weight_ext;
  logic                   first_ok, second_ok;
  logic [AddrW-1:0]       first_addr, second_addr;
  logic [WEIGHT_BITS-1:0] load_w;

  // Charge stage registers.
  logic            busy_q, busy_d;
  logic [ID_W-1:0] first_id_q, second_id_q;
  logic            first_ok_q, second_ok_q;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic [ID_W-1:0]    cover_q;
  logic [FIELD_W-1:0] price_q;

  // Memory ports.
  logic                   en0, we0, en1, we1;
  logic [AddrW-1:0]       addr0, addr1;
  logic [WEIGHT_BITS-1:0] wdata0, wdata1, rdata0, rdata1;

  // Charge results.
  logic [WEIGHT_BITS-1:0] first_w, second_w, price_w, rest_w;
  charge_t                charge;
  logic                   hold, done;
  logic [ID_W-1:0]        winner_id, loser_id;
  logic [31:0]            winner_ext, loser_ext, price_ext;

  assign item_i.ready = !busy_q;
  assign accept       = item_i.valid && item_i.ready;
  assign is_edge      = (action_e'(item_i.action) == ACT_EDGE);

  assign first_ext   = 32'(item_i.first_vertex);
  assign second_ext  = 32'(item_i.second_vertex);
  assign weight_ext  = 32'(item_i.weight);
  assign first_ok    = first_ext < 32'(MAX_VERTICES);
  assign second_ok   = second_ext < 32'(MAX_VERTICES);
  assign first_addr  = first_ext[AddrW-1:0];
  assign second_addr = second_ext[AddrW-1:0];
  assign load_w      = weight_ext[WEIGHT_BITS-1:0];

  // Ids that address no entry read as zero weight.
  assign first_w  = first_ok_q ? rdata0 : '0;
  assign second_w = second_ok_q ? rdata1 : '0;

  pvc_charge #(
    .WeightW (WEIGHT_BITS)
  ) u_charge (
    .first_w_i  (first_w),
    .second_w_i (second_w),
    .same_id_i  (first_id_q == second_id_q),
    .charge_o   (charge),
    .price_o    (price_w),
    .rest_o     (rest_w)
  );

  assign winner_id  = charge.first_wins ? first_id_q : second_id_q;
  assign loser_id   = charge.first_wins ? second_id_q : first_id_q;
  assign winner_ext = 32'(winner_id);
  assign loser_ext  = 32'(loser_id);
  assign price_ext  = 32'(price_w);

  // The stage finishes unless a charged edge finds the result register blocked.
  assign hold = charge.emit && out_valid_q && !result_o.ready;
  assign done = busy_q && !hold;

  // Port use: the accept cycle reads or loads, the charge cycle writes back.
  always_comb begin
    if (busy_q) begin
      en0    = done && charge.emit;
      we0    = 1'b1;
      addr0  = winner_ext[AddrW-1:0];
      wdata0 = '0;
      en1    = done && charge.emit && !charge.self_loop;
      we1    = 1'b1;
      addr1  = loser_ext[AddrW-1:0];
      wdata1 = rest_w;
    end else begin
      en0    = accept && (is_edge || first_ok);
      we0    = !is_edge;
      addr0  = first_addr;
      wdata0 = load_w;
      en1    = accept && is_edge;
      we1    = 1'b0;
      addr1  = second_addr;
      wdata1 = '0;
    end
  end

  pvc_table #(
    .Depth (MAX_VERTICES),
    .DataW (WEIGHT_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .en0_i    (en0),
    .we0_i    (we0),
    .addr0_i  (addr0),
    .wdata0_i (wdata0),
    .rdata0_o (rdata0),
    .en1_i    (en1),
    .we1_i    (we1),
    .addr1_i  (addr1),
    .wdata1_i (wdata1),
    .rdata1_o (rdata1)
  );

  // Next state of the stage and of the result register.
  always_comb begin
    busy_d = busy_q;
    if (accept && is_edge) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (done && charge.emit) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Edge endpoints captured at accept; result payload captured at charge.
  always_ff @(posedge clk_i) begin
    if (accept && is_edge) begin
      first_id_q  <= item_i.first_vertex;
      second_id_q <= item_i.second_vertex;
      first_ok_q  <= first_ok;
      second_ok_q <= second_ok;
    end
    if (done && charge.emit) begin
      cover_q <= winner_id;
      price_q <= price_ext[FIELD_W-1:0];
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.cover_vertex = cover_q;
  assign result_o.price        = price_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for pricing_vertex_cover_approx_core: directed cases, random streams
// under four idling mixes and a long result stall. Depends on pvc_pkg and pvc_if.
// A local model of the remaining-weight table predicts every charged edge.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pvc_pkg::*;

  localparam int unsigned NUM_VERTICES = 1024;
  localparam int unsigned RECENT_DEPTH = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expected result: the vertex put into the cover and what it cost.
  typedef struct packed {
    logic [ID_W-1:0]    cover_vertex;
    logic [FIELD_W-1:0] price;
  } cover_charge_t;

  logic clk_i;
  logic rst_ni;

  pvc_item_if   item_bus ();
  pvc_result_if result_bus ();

  pricing_vertex_cover_approx_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // Local copy of the remaining-weight table and what has been loaded so far.
  logic [FIELD_W-1:0] rem_weight [NUM_VERTICES];
  bit                 is_loaded  [NUM_VERTICES];
  int                 loaded_ids [$];
  int                 recent_ids [$];
  cover_charge_t      expected_charges [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  logic        hold_active;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned n_loads;
  int unsigned n_edges;
  int unsigned n_skipped;
  int unsigned n_checked;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
  endfunction

  // Apply one accepted beat to the table model; charged edges queue a result.
  function automatic void price_item(input action_e act, input logic [ID_W-1:0] a,
                                     input logic [ID_W-1:0] b,
                                     input logic [FIELD_W-1:0] w);
    logic [FIELD_W-1:0] wa;
    logic [FIELD_W-1:0] wb;
    logic [FIELD_W-1:0] price;
    logic [ID_W-1:0]    winner;
    logic [ID_W-1:0]    loser;
    cover_charge_t      charge;
    if (act == ACT_LOAD) begin
      n_loads++;
      rem_weight[a] = w;
      if (!is_loaded[a]) begin
        is_loaded[a] = 1'b1;
        loaded_ids.push_back(int'(a));
      end
      recent_ids.push_back(int'(a));
      if (recent_ids.size() > RECENT_DEPTH) void'(recent_ids.pop_front());
      return;
    end
    n_edges++;
    wa = rem_weight[a];
    wb = rem_weight[b];
    if (wa == '0 || wb == '0) begin
      n_skipped++;
      return;
    end
    // Strictly smaller first endpoint wins, otherwise the second one does.
    if (wa < wb) begin
      winner = a;
      loser  = b;
      price  = wa;
    end else begin
      winner = b;
      loser  = a;
      price  = wb;
    end
    // The winner is charged first, so a self-loop sees its own cleared entry.
    rem_weight[winner] = (rem_weight[winner] > price) ? rem_weight[winner] - price : '0;
    rem_weight[loser]  = (rem_weight[loser] > price) ? rem_weight[loser] - price : '0;
    charge.cover_vertex = winner;
    charge.price        = price;
    expected_charges.push_back(charge);
  endfunction

  // Compare one result beat against the oldest expected charge.
  function automatic void check_charge(input logic [ID_W-1:0] cv,
                                       input logic [FIELD_W-1:0] pr);
    cover_charge_t want;
    if (expected_charges.size() == 0) begin
      note_mismatch($sformatf("unexpected result vertex=%0d price=%0d", cv, pr));
      return;
    end
    want = expected_charges.pop_front();
    n_checked++;
    if (cv !== want.cover_vertex || pr !== want.price)
      note_mismatch($sformatf("vertex exp=%0d got=%0d, price exp=%0d got=%0d",
                              want.cover_vertex, cv, want.price, pr));
  endfunction

  // Long receiver hold-off, counted here so the sender keeps offering beats.
  initial begin
    hold_active = 1'b0;
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      hold_active <= 1'b1;
      for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      hold_active <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // Result side: check each accepted beat, then pick the next ready value.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_bus.valid && result_bus.ready)
        check_charge(result_bus.cover_vertex, result_bus.price);
      if (hold_active) begin
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat after an optional idle gap and wait for it to be taken.
  task automatic send_item(input action_e act, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b, input logic [FIELD_W-1:0] w);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid         <= 1'b1;
    item_bus.action        <= act;
    item_bus.first_vertex  <= a;
    item_bus.second_vertex <= b;
    item_bus.weight        <= w;
    do @(posedge clk_i); while (!item_bus.ready);
    price_item(act, a, b, w);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Drop valid and wait until every expected charge has come back.
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (expected_charges.size() != 0 || hold_req) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_recent();
    return recent_ids[$urandom_range(recent_ids.size() - 1)];
  endfunction

  // Extreme ids and weights, ties, zero endpoints, reloads and self-loops.
  task automatic test_directed_cases();
    send_item(ACT_LOAD, 10'd0,    10'd1023, 16'hFFFF);
    send_item(ACT_LOAD, 10'd1023, 10'd0,    16'd1);
    send_item(ACT_LOAD, 10'd5,    10'd0,    16'd0);
    send_item(ACT_LOAD, 10'd6,    10'd0,    16'd100);
    send_item(ACT_LOAD, 10'd7,    10'd0,    16'd100);
    send_item(ACT_LOAD, 10'd8,    10'd0,    16'd300);
    // Smaller second endpoint wins, then the edge is seen as covered.
    send_item(ACT_EDGE, 10'd0,    10'd1023, 16'hFFFF);
    send_item(ACT_EDGE, 10'd1023, 10'd0,    16'd0);
    // Either endpoint at zero weight skips the edge.
    send_item(ACT_EDGE, 10'd5,    10'd6,    16'd0);
    send_item(ACT_EDGE, 10'd6,    10'd5,    16'd0);
    // Equal weights: the second endpoint takes the cover.
    send_item(ACT_EDGE, 10'd6,    10'd7,    16'd0);
    // Reload a cleared vertex; smaller first endpoint wins.
    send_item(ACT_LOAD, 10'd6,    10'd0,    16'd50);
    send_item(ACT_EDGE, 10'd6,    10'd8,    16'd0);
    send_item(ACT_EDGE, 10'd8,    10'd0,    16'd0);
    // Self-loop clears the vertex, and a second one is skipped.
    send_item(ACT_EDGE, 10'd0,    10'd0,    16'd0);
    send_item(ACT_EDGE, 10'd0,    10'd0,    16'd0);
    // Full-scale tie on the extreme ids.
    send_item(ACT_LOAD, 10'd0,    10'd0,    16'hFFFF);
    send_item(ACT_LOAD, 10'd1023, 10'd0,    16'hFFFF);
    send_item(ACT_EDGE, 10'd0,    10'd1023, 16'd0);
    send_item(ACT_EDGE, 10'd1023, 10'd0,    16'd0);
  endtask

  // Mostly edges between freshly loaded vertices, with some reaching further back.
  task automatic test_random_stream(input int unsigned count);
    int unsigned pick;
    int          a;
    int          b;
    logic [FIELD_W-1:0] w;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (recent_ids.size() < 2 || $urandom_range(99) < 30) begin
        if (pick < 5)       w = '0;
        else if (pick < 10) w = '1;
        else if (pick < 35) w = FIELD_W'($urandom_range(8, 1));
        else                w = FIELD_W'($urandom_range(16'hFFFF));
        send_item(ACT_LOAD, ID_W'($urandom_range(1023)), ID_W'($urandom_range(1023)), w);
      end else begin
        if (pick < 10) begin
          a = pick_recent();
          b = a;
        end else if (pick < 20) begin
          a = loaded_ids[$urandom_range(loaded_ids.size() - 1)];
          b = loaded_ids[$urandom_range(loaded_ids.size() - 1)];
        end else begin
          a = pick_recent();
          b = pick_recent();
        end
        send_item(ACT_EDGE, ID_W'(a), ID_W'(b), FIELD_W'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  // Hold the result side off while charged edges keep arriving.
  task automatic test_result_backpressure();
    int a;
    int b;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      a = int'($urandom_range(1023));
      b = int'($urandom_range(1023));
      send_item(ACT_LOAD, ID_W'(a), ID_W'($urandom_range(1023)),
                FIELD_W'($urandom_range(16'hFFFF, 1)));
      send_item(ACT_LOAD, ID_W'(b), ID_W'($urandom_range(1023)),
                FIELD_W'($urandom_range(16'hFFFF, 1)));
      send_item(ACT_EDGE, ID_W'(a), ID_W'(b), FIELD_W'($urandom_range(16'hFFFF)));
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni                 = 1'b0;
    hold_req               = 1'b0;
    mismatches             = 0;
    n_loads                = 0;
    n_edges                = 0;
    n_skipped              = 0;
    n_checked              = 0;
    item_bus.valid         <= 1'b0;
    item_bus.action        <= ACT_LOAD;
    item_bus.first_vertex  <= '0;
    item_bus.second_vertex <= '0;
    item_bus.weight        <= '0;
    set_idling(0, 0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    wait_drained();
    test_random_stream(200);
    wait_drained();
    set_idling(67, 0);
    test_random_stream(200);
    wait_drained();
    set_idling(0, 67);
    test_random_stream(200);
    wait_drained();
    set_idling(15, 15);
    test_random_stream(200);
    wait_drained();
    set_idling(0, 0);
    test_result_backpressure();
    wait_drained();

    $display("Ran %0d loads and %0d edges (%0d charged and checked, %0d already covered)",
             n_loads, n_edges, n_checked, n_skipped);
    $display("across four idling mixes and a %0d-cycle result stall; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/pvc_pkg.sv
design/pvc_if.sv
design/pvc_table.sv
design/pvc_charge.sv
design/pricing_vertex_cover_approx_core.sv
sim/tb_top.sv
